@@ sv/sbpf_pkg.sv @@
package sbpf_pkg;

  localparam int MAXF_W              = 17;
  localparam logic [MAXF_W-1:0] MAXF_RESET = 17'd35000;
  localparam int LENGTH_BITS_DEFAULT = 16;
  localparam int MAX_LENGTH_BITS     = 24;
  localparam int PKT_W               = MAX_LENGTH_BITS + 1;
  localparam int PAD_W               = 4;
  localparam int HDR_CNT_W           = 3;
  localparam logic [HDR_CNT_W-1:0] HDR_PAD_STEP = 3'd4;
  localparam int CMD_DEPTH           = 4;
  localparam int CMD_PTR_W           = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W           = $clog2(CMD_DEPTH + 1);

  // One request from the front end: which parts of the frame to emit for one item.
  typedef struct packed {
    logic             err;
    logic             hdr;
    logic             data_v;
    logic             pad_v;
    logic [PKT_W-1:0] pkt_len;
    logic [PAD_W-1:0] pad;
    logic [7:0]       data;
  } cmd_t;

  // Padding that brings 5 + length up to a multiple of 8, at least 4 bytes.
  function automatic logic [PAD_W-1:0] pad_for(input logic [2:0] len_low);
    logic [2:0]       rem;
    logic [PAD_W-1:0] p;
    rem = len_low + 3'd5;
    p   = 4'd8 - {1'b0, rem};
    if (p < 4'd4) begin
      p = p + 4'd8;
    end
    return p;
  endfunction

endpackage

@@ sv/sbpf_front.sv @@
module sbpf_front
  import sbpf_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [MAXF_W-1:0]      cfg_data,
  input  logic                   accept,
  input  logic [LENGTH_BITS-1:0] payload_length,
  input  logic [7:0]             data_byte,
  input  logic                   has_byte,
  output logic                   cmd_push,
  output cmd_t                   cmd
);

  localparam int FRAME_W = LENGTH_BITS + 1;
  localparam int CMP_W   = (FRAME_W > MAXF_W) ? FRAME_W : MAXF_W;

  logic [MAXF_W-1:0]      max_frame_bytes;
  logic [LENGTH_BITS-1:0] bytes_seen, bytes_seen_next;
  logic [LENGTH_BITS-1:0] held_length, held_length_next;
  logic [PAD_W-1:0]       pad_amount, pad_amount_next;
  logic                   in_frame, in_frame_next;
  logic                   dropping, dropping_next;

  always_comb begin
    logic [PAD_W-1:0]       padv;
    logic [FRAME_W-1:0]     frame;
    logic [LENGTH_BITS-1:0] seen;
    logic                   err_path;
    bytes_seen_next  = bytes_seen;
    held_length_next = held_length;
    pad_amount_next  = pad_amount;
    in_frame_next    = in_frame;
    dropping_next    = dropping;
    cmd              = '0;
    cmd.data         = data_byte;
    padv             = pad_for(payload_length[2:0]);
    frame            = {1'b0, payload_length} + FRAME_W'(padv) + FRAME_W'(5);
    seen             = bytes_seen;
    err_path         = 1'b0;
    if (dropping) begin
      seen = has_byte ? LENGTH_BITS'(bytes_seen + 1'b1) : bytes_seen;
      if (seen >= held_length) begin
        dropping_next    = 1'b0;
        bytes_seen_next  = '0;
        held_length_next = '0;
      end else begin
        bytes_seen_next = seen;
      end
    end else begin
      if (!in_frame) begin
        if (CMP_W'(frame) > CMP_W'(max_frame_bytes)) begin
          err_path = 1'b1;
          cmd.err  = 1'b1;
          if (payload_length != '0) begin
            seen = has_byte ? LENGTH_BITS'(1) : '0;
            if (seen < payload_length) begin
              dropping_next    = 1'b1;
              held_length_next = payload_length;
              bytes_seen_next  = seen;
            end else begin
              bytes_seen_next  = '0;
              held_length_next = '0;
            end
          end
        end else begin
          cmd.hdr          = 1'b1;
          cmd.pkt_len      = PKT_W'(frame - FRAME_W'(4));
          held_length_next = payload_length;
          pad_amount_next  = padv;
          bytes_seen_next  = '0;
          in_frame_next    = 1'b1;
        end
      end
      if (!err_path) begin
        cmd.pad = pad_amount_next;
        if (has_byte && (bytes_seen_next < held_length_next)) begin
          cmd.data_v      = 1'b1;
          bytes_seen_next = LENGTH_BITS'(bytes_seen_next + 1'b1);
        end
        if (bytes_seen_next >= held_length_next) begin
          cmd.pad_v        = 1'b1;
          in_frame_next    = 1'b0;
          bytes_seen_next  = '0;
          held_length_next = '0;
          pad_amount_next  = '0;
        end
      end
    end
    cmd_push = accept && (cmd.err || cmd.hdr || cmd.data_v || cmd.pad_v);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_bytes <= MAXF_RESET;
      bytes_seen      <= '0;
      held_length     <= '0;
      pad_amount      <= '0;
      in_frame        <= 1'b0;
      dropping        <= 1'b0;
    end else begin
      if (cfg_write) begin
        max_frame_bytes <= cfg_data;
      end
      if (accept) begin
        bytes_seen  <= bytes_seen_next;
        held_length <= held_length_next;
        pad_amount  <= pad_amount_next;
        in_frame    <= in_frame_next;
        dropping    <= dropping_next;
      end
    end
  end

endmodule

@@ sv/sbpf_cmd_fifo.sv @@
module sbpf_cmd_fifo
  import sbpf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_cmd,
  input  logic rd_en,
  output cmd_t rd_cmd,
  output logic fifo_full,
  output logic fifo_empty
);

  cmd_t                 mem [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr;
  logic [CMD_PTR_W-1:0] rd_ptr;
  logic [CMD_CNT_W-1:0] count;

  assign fifo_full  = (count == CMD_CNT_W'(CMD_DEPTH));
  assign fifo_empty = (count == '0);
  assign rd_cmd     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= CMD_PTR_W'(wr_ptr + 1'b1);
      end
      if (rd_en) begin
        rd_ptr <= CMD_PTR_W'(rd_ptr + 1'b1);
      end
      if (wr_en && !rd_en) begin
        count <= CMD_CNT_W'(count + 1'b1);
      end else if (rd_en && !wr_en) begin
        count <= CMD_CNT_W'(count - 1'b1);
      end
    end
  end

endmodule

@@ sv/sbpf_back.sv @@
module sbpf_back
  import sbpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       head,
  input  logic       fifo_empty,
  output logic       fifo_pop,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic       frame_last,
  output logic       too_long
);

  cmd_t                 cur, cur_next;
  logic [HDR_CNT_W-1:0] hcnt, hcnt_next;
  logic [PAD_W-1:0]     pcnt, pcnt_next;
  logic                 out_valid;
  logic [7:0]           byte_sel;
  logic                 last_sel;
  logic                 err_sel;
  logic                 step;

  always_comb begin
    cmd_t        work;
    logic [31:0] pkt32;
    logic        busy_after;
    work      = cur;
    hcnt_next = hcnt;
    pcnt_next = pcnt;
    byte_sel  = '0;
    last_sel  = 1'b0;
    err_sel   = 1'b0;
    pkt32     = 32'(cur.pkt_len);
    step      = (cur.err || cur.hdr || cur.data_v || cur.pad_v) && (!out_valid || pop);
    if (cur.err) begin
      last_sel = 1'b1;
      err_sel  = 1'b1;
      work.err = 1'b0;
    end else if (cur.hdr) begin
      case (hcnt)
        3'd0:    byte_sel = pkt32[31:24];
        3'd1:    byte_sel = pkt32[23:16];
        3'd2:    byte_sel = pkt32[15:8];
        3'd3:    byte_sel = pkt32[7:0];
        default: byte_sel = 8'(cur.pad);
      endcase
      if (hcnt == HDR_PAD_STEP) begin
        work.hdr  = 1'b0;
        hcnt_next = '0;
      end else begin
        hcnt_next = HDR_CNT_W'(hcnt + 1'b1);
      end
    end else if (cur.data_v) begin
      byte_sel    = cur.data;
      work.data_v = 1'b0;
    end else if (cur.pad_v) begin
      last_sel = (PAD_W'(pcnt + 1'b1) == cur.pad);
      if (last_sel) begin
        work.pad_v = 1'b0;
        pcnt_next  = '0;
      end else begin
        pcnt_next = PAD_W'(pcnt + 1'b1);
      end
    end
    if (!step) begin
      work      = cur;
      hcnt_next = hcnt;
      pcnt_next = pcnt;
    end
    busy_after = work.err || work.hdr || work.data_v || work.pad_v;
    fifo_pop   = !busy_after && !fifo_empty;
    cur_next   = fifo_pop ? head : work;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur       <= '0;
      hcnt      <= '0;
      pcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      cur  <= cur_next;
      hcnt <= hcnt_next;
      pcnt <= pcnt_next;
      if (step) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_byte   <= byte_sel;
      frame_last <= last_sel;
      too_long   <= err_sel;
    end
  end

  assign empty = !out_valid;

endmodule

@@ sv/ssh_binary_packet_framer.sv @@
// Frames one payload at a time into an SSH binary packet (no MAC, no cipher).
// Input side is a queue: drive push with payload_length, data_byte and has_byte
// while full is low. The first request of a payload carries its length; an empty
// payload is a single request with has_byte low.
// Output side is a queue too: while empty is low, out_byte, frame_last and
// too_long hold the oldest byte, taken with pop. A frame is the 4-byte packet
// length, the padding-length byte, the payload and 4 to 11 zero padding bytes,
// with frame_last on the final padding byte. An oversized frame gives a single
// result with too_long and frame_last set, and its payload is discarded.
// cfg_write/cfg_data set the largest frame size; write only while idle.
// Throughput: one request per cycle while full is low; the back end emits one byte
// per cycle while the receiver pops, so the 5 header and 4 to 11 padding bytes of
// each frame are paced by the output register, and the 4-entry request queue raises
// full while they drain. Requests go through the queue, cur and the output register.
// When the receiver stalls, the output holds and the queue fills, then full rises.
// Reset empties both sides, clears the frame state and restores the size limit
// to 35000 bytes.
module ssh_binary_packet_framer
  import sbpf_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [MAXF_W-1:0]      cfg_data,
  input  logic                   push,
  output logic                   full,
  input  logic [LENGTH_BITS-1:0] payload_length,
  input  logic [7:0]             data_byte,
  input  logic                   has_byte,
  output logic                   empty,
  input  logic                   pop,
  output logic [7:0]             out_byte,
  output logic                   frame_last,
  output logic                   too_long
);

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic cmd_push;
  logic cmd_pop;
  logic fifo_full;
  logic fifo_empty;

  assign full = fifo_full;

  sbpf_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .accept        (push && !fifo_full),
    .payload_length(payload_length),
    .data_byte     (data_byte),
    .has_byte      (has_byte),
    .cmd_push      (cmd_push),
    .cmd           (front_cmd)
  );

  sbpf_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (cmd_push),
    .wr_cmd    (front_cmd),
    .rd_en     (cmd_pop),
    .rd_cmd    (head_cmd),
    .fifo_full (fifo_full),
    .fifo_empty(fifo_empty)
  );

  sbpf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head_cmd),
    .fifo_empty(fifo_empty),
    .fifo_pop  (cmd_pop),
    .pop       (pop),
    .empty     (empty),
    .out_byte  (out_byte),
    .frame_last(frame_last),
    .too_long  (too_long)
  );

endmodule
